[rtl/core/hkr_pkg.sv]
// shared types, constants and the built-in key table for the keyboard report translator
package hkr_pkg;

    localparam int KEYMAP_SIZE = 384;
    localparam int KEYS        = 6;
    localparam int SEQ_MAX     = 6;
    localparam int MAP_AW      = 9;
    localparam int KEY_IW      = 3;
    localparam int IN_W        = 80;

    localparam logic [1:0] OP_REPORT    = 2'd0;
    localparam logic [1:0] OP_TICK      = 2'd1;
    localparam logic [1:0] OP_MAP_WRITE = 2'd2;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_IRQ  = 2'd1;
    localparam logic [1:0] KIND_LEDS = 2'd2;

    localparam logic [1:0] CFG_KEYMAP_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_INTERRUPT_CHAR = 2'd1;
    localparam logic [1:0] CFG_REPEAT_DELAY   = 2'd2;
    localparam logic [1:0] CFG_REPEAT_PERIOD  = 2'd3;

    localparam logic [7:0] KEY_NUM_LOCK  = 8'h53;
    localparam logic [7:0] KEY_CAPS_LOCK = 8'h39;
    localparam logic [7:0] KEY_ROLLOVER  = 8'h01;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_KEY,
        S_LOOK,
        S_PLAY,
        S_LED,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [MAP_AW-1:0] map_len;
        logic              altgr_en;
        logic              irq_en;
        logic [7:0]        irq_char;
        logic [15:0]       delay;
        logic [15:0]       period;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [MAP_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [MAP_AW-1:0] raddr;
    } t_mem_req;

    // bytes: first byte in the top bits
    typedef struct packed {
        logic        found;
        logic [2:0]  len;
        logic [47:0] bytes;
    } t_tbl;

    function automatic t_tbl mkseq(input logic [2:0] len, input logic [47:0] bytes);
        t_tbl t;
        t.found = 1'b1;
        t.len   = len;
        t.bytes = bytes;
        return t;
    endfunction

    function automatic logic [7:0] shifted_digit(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0:    c = 8'h21;
            4'd1:    c = 8'h40;
            4'd2:    c = 8'h23;
            4'd3:    c = 8'h24;
            4'd4:    c = 8'h25;
            4'd5:    c = 8'h5e;
            4'd6:    c = 8'h26;
            4'd7:    c = 8'h2a;
            4'd8:    c = 8'h28;
            default: c = 8'h29;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] punct_byte(input logic [4:0] i, input logic shift);
        logic [7:0] c;
        case (i)
            5'd0:    c = shift ? 8'h0a : 8'h0d;
            5'd1:    c = 8'h1b;
            5'd2:    c = shift ? 8'h7f : 8'h08;
            5'd3:    c = 8'h09;
            5'd4:    c = 8'h20;
            5'd5:    c = shift ? 8'h5f : 8'h2d;
            5'd6:    c = shift ? 8'h2b : 8'h3d;
            5'd7:    c = shift ? 8'h7b : 8'h5b;
            5'd8:    c = shift ? 8'h7d : 8'h5d;
            5'd9:    c = shift ? 8'h7c : 8'h5c;
            5'd10:   c = shift ? 8'h7e : 8'h23;
            5'd11:   c = shift ? 8'h3a : 8'h3b;
            5'd12:   c = shift ? 8'h22 : 8'h27;
            5'd13:   c = shift ? 8'h7e : 8'h60;
            5'd14:   c = shift ? 8'h3c : 8'h2c;
            5'd15:   c = shift ? 8'h3e : 8'h2e;
            default: c = shift ? 8'h3f : 8'h2f;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] keypad_byte(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0:    c = 8'h2f;
            4'd1:    c = 8'h2a;
            4'd2:    c = 8'h2d;
            4'd3:    c = 8'h2b;
            4'd4:    c = 8'h0a;
            4'd14:   c = 8'h30;
            4'd15:   c = 8'h2e;
            default: c = 8'h2c + {4'd0, i};
        endcase
        return c;
    endfunction

    function automatic t_tbl keypad_nav(input logic [3:0] i);
        t_tbl t;
        case (i)
            4'd0:    t = mkseq(3'd1, 48'h2f0000000000);
            4'd1:    t = mkseq(3'd1, 48'h2a0000000000);
            4'd2:    t = mkseq(3'd1, 48'h2d0000000000);
            4'd3:    t = mkseq(3'd1, 48'h2b0000000000);
            4'd4:    t = mkseq(3'd1, 48'h0a0000000000);
            4'd5:    t = mkseq(3'd3, 48'h1b5b46000000);
            4'd6:    t = mkseq(3'd3, 48'h1b5b42000000);
            4'd7:    t = mkseq(3'd4, 48'h1b5b367e0000);
            4'd8:    t = mkseq(3'd3, 48'h1b5b44000000);
            4'd9:    t = mkseq(3'd0, 48'h000000000000);
            4'd10:   t = mkseq(3'd3, 48'h1b5b43000000);
            4'd11:   t = mkseq(3'd3, 48'h1b5b48000000);
            4'd12:   t = mkseq(3'd3, 48'h1b5b41000000);
            4'd13:   t = mkseq(3'd4, 48'h1b5b357e0000);
            4'd14:   t = mkseq(3'd4, 48'h1b5b327e0000);
            default: t = mkseq(3'd4, 48'h1b5b337e0000);
        endcase
        return t;
    endfunction

    function automatic t_tbl fkey_seq(input logic [3:0] i);
        t_tbl t;
        case (i)
            4'd0:    t = mkseq(3'd3, 48'h1b4f50000000);
            4'd1:    t = mkseq(3'd3, 48'h1b4f51000000);
            4'd2:    t = mkseq(3'd3, 48'h1b4f52000000);
            4'd3:    t = mkseq(3'd3, 48'h1b4f53000000);
            4'd4:    t = mkseq(3'd5, 48'h1b5b31357e00);
            4'd5:    t = mkseq(3'd5, 48'h1b5b31377e00);
            4'd6:    t = mkseq(3'd5, 48'h1b5b31387e00);
            4'd7:    t = mkseq(3'd5, 48'h1b5b31397e00);
            4'd8:    t = mkseq(3'd5, 48'h1b5b32307e00);
            4'd9:    t = mkseq(3'd5, 48'h1b5b32317e00);
            4'd10:   t = mkseq(3'd5, 48'h1b5b32337e00);
            4'd11:   t = mkseq(3'd5, 48'h1b5b32347e00);
            default: t = mkseq(3'd3, 48'h1b5b69000000);
        endcase
        return t;
    endfunction

    function automatic t_tbl arrow_seq(input logic [1:0] i, input logic ctrl);
        logic [7:0] d;
        t_tbl       t;
        case (i)
            2'd0:    d = 8'h43;
            2'd1:    d = 8'h44;
            2'd2:    d = 8'h42;
            default: d = 8'h41;
        endcase
        if (ctrl) begin
            t = mkseq(3'd6, {40'h1b5b313b35, d});
        end else begin
            t = mkseq(3'd3, {16'h1b5b, d, 24'h000000});
        end
        return t;
    endfunction

    function automatic t_tbl tbl_lookup(input logic [7:0] key, input logic shift,
                                        input logic ctrl, input logic alt,
                                        input logic caps, input logic num);
        t_tbl       t;
        logic [7:0] code;
        logic [7:0] off;
        logic       is_byte;
        t       = '0;
        code    = '0;
        is_byte = 1'b0;
        off     = '0;
        if (!ctrl && key >= 8'h04 && key <= 8'h1d) begin
            code    = key + 8'h5d;
            is_byte = 1'b1;
        end else if (!ctrl && key >= 8'h1e && key <= 8'h26) begin
            off     = key - 8'h1e;
            code    = shift ? shifted_digit(off[3:0]) : 8'h31 + off;
            is_byte = 1'b1;
        end else if (!ctrl && key == 8'h27) begin
            code    = shift ? 8'h29 : 8'h30;
            is_byte = 1'b1;
        end else if (ctrl && key == 8'h28) begin
            code    = 8'h0a;
            is_byte = 1'b1;
        end else if (!ctrl && key >= 8'h28 && key <= 8'h38) begin
            off     = key - 8'h28;
            code    = punct_byte(off[4:0], shift);
            is_byte = 1'b1;
        end else if (!ctrl && key >= 8'h54 && key <= 8'h63) begin
            off = key - 8'h54;
            if (num) begin
                t = keypad_nav(off[3:0]);
            end else begin
                code    = keypad_byte(off[3:0]);
                is_byte = 1'b1;
            end
        end else if (!ctrl && key == 8'h48) begin
            code    = 8'h1a;
            is_byte = 1'b1;
        end else if (!ctrl && key == 8'h4e) begin
            t = mkseq(3'd4, 48'h1b5b367e0000);
        end else if (!ctrl && key == 8'h4b) begin
            t = mkseq(3'd4, 48'h1b5b357e0000);
        end else if (!ctrl && key == 8'h4a) begin
            t = mkseq(3'd3, 48'h1b5b48000000);
        end else if (!ctrl && key == 8'h4d) begin
            t = mkseq(3'd3, 48'h1b5b46000000);
        end else if (!ctrl && key == 8'h49) begin
            t = mkseq(3'd4, 48'h1b5b327e0000);
        end else if (!ctrl && key == 8'h4c) begin
            t = mkseq(3'd4, 48'h1b5b337e0000);
        end else if (!ctrl && key >= 8'h3a && key <= 8'h46) begin
            off = key - 8'h3a;
            t   = fkey_seq(off[3:0]);
        end else if (key >= 8'h4f && key <= 8'h52) begin
            off = key - 8'h4f;
            t   = arrow_seq(off[1:0], ctrl);
        end
        if (is_byte) begin
            if (code >= 8'h61 && code <= 8'h7a && (shift != caps)) begin
                code = code ^ 8'h20;
            end
            if (ctrl) begin
                code = code & 8'h1f;
            end
            if (alt) begin
                code = code ^ 8'h80;
            end
            t = mkseq(3'd1, {code, 40'h0});
        end
        return t;
    endfunction

endpackage

[rtl/core/hid_keyboard_report_to_ascii.sv]
// top level: configuration registers, keymap memory and the key sequencer
//
// channel   direction  handshake                    payload
// s_axis    in         i_s_axis_tvalid/o_..._tready  tdata keys and keymap write, tuser operation
// m_axis    out        o_m_axis_tvalid/i_..._tready  tdata value, tuser kind, tlast
// cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// an interrupt byte ends the sequence that it is in
// after reset the keymap is cleared before the first input is taken
// a stalled output holds the sequencer once one result is held back
module hid_keyboard_report_to_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // modifiers, key0..key5, map_index, map_value, zero pad
    input  logic [79:0] i_s_axis_tdata,
    // operation
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // value
    output logic [7:0]  o_m_axis_tdata,
    // kind
    output logic [1:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [8:0]  r_map_len;
    logic [8:0]  r_irq;
    logic [15:0] r_delay;
    logic [15:0] r_period;
    hkr_pkg::t_cfg     w_cfg;
    hkr_pkg::t_mem_req w_mem;
    logic [7:0]        w_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_len <= 9'd0;
            r_irq     <= 9'd3;
            r_delay   <= 16'd500;
            r_period  <= 16'd50;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hkr_pkg::CFG_KEYMAP_LENGTH:  r_map_len <= i_cfg_data[8:0];
                hkr_pkg::CFG_INTERRUPT_CHAR: r_irq     <= i_cfg_data[8:0];
                hkr_pkg::CFG_REPEAT_DELAY:   r_delay   <= i_cfg_data;
                hkr_pkg::CFG_REPEAT_PERIOD:  r_period  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_cfg.map_len  = (r_map_len > 9'(hkr_pkg::KEYMAP_SIZE))
                       ? 9'(hkr_pkg::KEYMAP_SIZE) : r_map_len;
        w_cfg.altgr_en = w_cfg.map_len > 9'd256;
        w_cfg.irq_en   = !r_irq[8];
        w_cfg.irq_char = r_irq[7:0];
        w_cfg.delay    = r_delay;
        w_cfg.period   = r_period;
    end

    hkr_keymap u_keymap (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    hkr_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_mem           (w_mem),
        .i_mem_rdata     (w_rdata)
    );

endmodule

[rtl/core/hkr_keymap.sv]
// user keymap memory, one write and one registered read port
module hkr_keymap (
    input  logic              i_clk,
    input  hkr_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [hkr_pkg::KEYMAP_SIZE];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

[rtl/core/hkr_core.sv]
// sequencer: walks the report keys, looks up bytes, plays sequences and handles repeat
module hkr_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hkr_pkg::t_cfg              i_cfg,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [hkr_pkg::IN_W-1:0]   i_s_axis_tdata,
    input  logic [1:0]                 i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [7:0]                 o_m_axis_tdata,
    output logic [1:0]                 o_m_axis_tuser,
    output logic                       o_m_axis_tlast,
    output hkr_pkg::t_mem_req          o_mem,
    input  logic [7:0]                 i_mem_rdata
);

    hkr_pkg::t_state r_state, n_state;

    logic [hkr_pkg::MAP_AW-1:0] r_clr, n_clr;
    logic [7:0]  r_keys [hkr_pkg::KEYS];
    logic [7:0]  n_keys [hkr_pkg::KEYS];
    logic [7:0]  r_prev [hkr_pkg::KEYS];
    logic [7:0]  n_prev [hkr_pkg::KEYS];
    logic [7:0]  r_rb   [hkr_pkg::SEQ_MAX];
    logic [7:0]  n_rb   [hkr_pkg::SEQ_MAX];
    logic [hkr_pkg::KEY_IW-1:0] r_i, n_i;
    logic [2:0]  r_rcnt, n_rcnt, r_pos, n_pos;
    logic        r_ract, n_ract;
    logic [15:0] r_cd, n_cd;
    logic [1:0]  r_leds, n_leds;
    logic        r_caps, n_caps, r_num, n_num;
    logic        r_shift, n_shift, r_ctrl, n_ctrl, r_alt, n_alt, r_altgr, n_altgr;
    logic        r_tick, n_tick, r_look_ok, n_look_ok;
    logic        r_hv, n_hv, r_ov, n_ov, r_olast, n_olast;
    logic [1:0]  r_hkind, n_hkind, r_okind, n_okind;
    logic [7:0]  r_hval, n_hval, r_oval, n_oval;

    logic [1:0]  w_op;
    logic [7:0]  w_mods;
    logic [7:0]  w_in_keys [hkr_pkg::KEYS];
    logic [hkr_pkg::MAP_AW-1:0] w_map_idx;
    logic [7:0]  w_map_val;
    logic        w_accept, w_rollover;
    logic [7:0]  w_key;
    logic        w_held, w_skip, w_last_key;
    logic [hkr_pkg::MAP_AW-1:0] w_idx;
    logic        w_idx_ok;
    logic [7:0]  w_ub, w_ubm;
    hkr_pkg::t_tbl w_tbl;
    logic [7:0]  w_pbyte;
    logic        w_play_end, w_irq_hit;
    logic [1:0]  w_new_leds;
    logic        w_out_free, w_can_emit, w_emit, w_fin_push;
    logic [1:0]  w_emit_kind;
    logic [7:0]  w_emit_val;
    logic        w_done_seq;

    always_comb begin
        w_op      = i_s_axis_tuser;
        w_mods    = i_s_axis_tdata[7:0];
        for (int k = 0; k < hkr_pkg::KEYS; k++) begin
            w_in_keys[k] = i_s_axis_tdata[8*k+8 +: 8];
        end
        w_map_idx = i_s_axis_tdata[64:56];
        w_map_val = i_s_axis_tdata[72:65];
        w_accept  = i_s_axis_tvalid && o_s_axis_tready;
        w_rollover = (w_in_keys[0] == hkr_pkg::KEY_ROLLOVER)
                  && (w_in_keys[1] == hkr_pkg::KEY_ROLLOVER);

        w_key = r_keys[r_i];
        w_held = 1'b0;
        for (int k = 0; k < hkr_pkg::KEYS; k++) begin
            if (r_prev[k] == w_key) begin
                w_held = 1'b1;
            end
        end
        w_skip = (w_key == 8'h00) || w_held || (w_key == hkr_pkg::KEY_NUM_LOCK)
              || (w_key == hkr_pkg::KEY_CAPS_LOCK);
        w_last_key = (r_i == hkr_pkg::KEY_IW'(hkr_pkg::KEYS - 1));
        w_idx = {1'b0, w_key} + (r_altgr ? 9'd256 : (r_shift ? 9'd128 : 9'd0));
        w_idx_ok = w_idx < i_cfg.map_len;

        w_ub = r_look_ok ? i_mem_rdata : 8'h00;
        if (r_ctrl) begin
            w_ubm = w_ub & 8'h1f;
        end else if (w_ub >= 8'h61 && w_ub <= 8'h7a && r_caps) begin
            w_ubm = w_ub ^ 8'h20;
        end else begin
            w_ubm = w_ub;
        end
        w_tbl = hkr_pkg::tbl_lookup(w_key, r_shift, r_ctrl, r_alt, r_caps, r_num);

        w_pbyte    = r_rb[r_pos];
        w_play_end = (r_pos == r_rcnt);
        w_irq_hit  = i_cfg.irq_en && (w_pbyte == i_cfg.irq_char);
        w_new_leds = {r_num, r_caps};

        w_out_free = !r_ov || i_m_axis_tready;
        w_can_emit = !r_hv || w_out_free;
        w_emit      = 1'b0;
        w_emit_kind = hkr_pkg::KIND_CHAR;
        w_emit_val  = w_pbyte;
        if (r_state == hkr_pkg::S_PLAY && !w_play_end) begin
            w_emit      = 1'b1;
            w_emit_kind = w_irq_hit ? hkr_pkg::KIND_IRQ : hkr_pkg::KIND_CHAR;
        end else if (r_state == hkr_pkg::S_LED && w_new_leds != r_leds) begin
            w_emit      = 1'b1;
            w_emit_kind = hkr_pkg::KIND_LEDS;
            w_emit_val  = {6'd0, w_new_leds};
        end
        w_fin_push = (r_state == hkr_pkg::S_FIN) && r_hv && w_out_free;
        w_done_seq = w_play_end || (w_can_emit && w_irq_hit);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hkr_pkg::S_CLEAR: begin
                if (r_clr == hkr_pkg::MAP_AW'(hkr_pkg::KEYMAP_SIZE - 1)) begin
                    n_state = hkr_pkg::S_IDLE;
                end
            end
            hkr_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_op == hkr_pkg::OP_TICK && r_ract && r_cd <= 16'd1) begin
                        n_state = hkr_pkg::S_PLAY;
                    end else if (w_op == hkr_pkg::OP_REPORT && !w_rollover) begin
                        n_state = hkr_pkg::S_KEY;
                    end
                end
            end
            hkr_pkg::S_KEY: begin
                if (!w_skip) begin
                    n_state = hkr_pkg::S_LOOK;
                end else if (w_last_key) begin
                    n_state = hkr_pkg::S_LED;
                end
            end
            hkr_pkg::S_LOOK: begin
                if (w_ub != 8'h00 || w_tbl.found) begin
                    n_state = hkr_pkg::S_PLAY;
                end else begin
                    n_state = w_last_key ? hkr_pkg::S_LED : hkr_pkg::S_KEY;
                end
            end
            hkr_pkg::S_PLAY: begin
                if (w_done_seq) begin
                    if (r_tick) begin
                        n_state = hkr_pkg::S_FIN;
                    end else begin
                        n_state = w_last_key ? hkr_pkg::S_LED : hkr_pkg::S_KEY;
                    end
                end
            end
            hkr_pkg::S_LED: begin
                if (w_new_leds == r_leds || w_can_emit) begin
                    n_state = hkr_pkg::S_FIN;
                end
            end
            hkr_pkg::S_FIN: begin
                if (!r_hv || w_out_free) begin
                    n_state = hkr_pkg::S_IDLE;
                end
            end
            default: n_state = hkr_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_clr     = r_clr;
        n_keys    = r_keys;
        n_prev    = r_prev;
        n_rb      = r_rb;
        n_i       = r_i;
        n_rcnt    = r_rcnt;
        n_pos     = r_pos;
        n_ract    = r_ract;
        n_cd      = r_cd;
        n_leds    = r_leds;
        n_caps    = r_caps;
        n_num     = r_num;
        n_shift   = r_shift;
        n_ctrl    = r_ctrl;
        n_alt     = r_alt;
        n_altgr   = r_altgr;
        n_tick    = r_tick;
        n_look_ok = r_look_ok;
        n_hv      = r_hv;
        n_hkind   = r_hkind;
        n_hval    = r_hval;
        n_ov      = r_ov;
        n_okind   = r_okind;
        n_oval    = r_oval;
        n_olast   = r_olast;
        o_mem.we    = 1'b0;
        o_mem.waddr = w_map_idx;
        o_mem.wdata = w_map_val;
        o_mem.raddr = w_idx_ok ? w_idx : '0;
        o_s_axis_tready = (r_state == hkr_pkg::S_IDLE);

        case (r_state)
            hkr_pkg::S_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_clr;
                o_mem.wdata = 8'h00;
                n_clr       = r_clr + 9'd1;
            end
            hkr_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        hkr_pkg::OP_MAP_WRITE: begin
                            o_mem.we = (w_map_idx < 9'(hkr_pkg::KEYMAP_SIZE));
                        end
                        hkr_pkg::OP_TICK: begin
                            if (r_ract) begin
                                if (r_cd > 16'd1) begin
                                    n_cd = r_cd - 16'd1;
                                end else begin
                                    n_cd   = i_cfg.period;
                                    n_pos  = 3'd0;
                                    n_tick = 1'b1;
                                end
                            end
                        end
                        hkr_pkg::OP_REPORT: begin
                            if (!w_rollover) begin
                                n_ract  = 1'b0;
                                n_keys  = w_in_keys;
                                n_i     = '0;
                                n_caps  = r_leds[0];
                                n_num   = r_leds[1];
                                n_tick  = 1'b0;
                                n_shift = |(w_mods & 8'h22);
                                n_ctrl  = |(w_mods & 8'h11);
                                n_altgr = i_cfg.altgr_en && w_mods[6];
                                n_alt   = i_cfg.altgr_en ? w_mods[2] : |(w_mods & 8'h44);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            hkr_pkg::S_KEY: begin
                n_look_ok = w_idx_ok;
                if (w_skip) begin
                    if (!w_held && w_key == hkr_pkg::KEY_NUM_LOCK) begin
                        n_num = !r_num;
                    end
                    if (!w_held && w_key == hkr_pkg::KEY_CAPS_LOCK) begin
                        n_caps = !r_caps;
                    end
                    if (!w_last_key) begin
                        n_i = r_i + 3'd1;
                    end
                end
            end
            hkr_pkg::S_LOOK: begin
                n_pos = 3'd0;
                if (w_ub != 8'h00) begin
                    n_rb[0] = w_ubm;
                    n_rcnt  = 3'd1;
                    n_ract  = 1'b1;
                    n_cd    = i_cfg.delay;
                end else if (w_tbl.found) begin
                    for (int k = 0; k < hkr_pkg::SEQ_MAX; k++) begin
                        n_rb[k] = w_tbl.bytes[47-8*k -: 8];
                    end
                    n_rcnt = w_tbl.len;
                    n_ract = 1'b1;
                    n_cd   = i_cfg.delay;
                end else if (!w_last_key) begin
                    n_i = r_i + 3'd1;
                end
            end
            hkr_pkg::S_PLAY: begin
                if (!w_play_end && w_can_emit) begin
                    n_pos = r_pos + 3'd1;
                end
                if (w_done_seq && !r_tick && !w_last_key) begin
                    n_i = r_i + 3'd1;
                end
            end
            hkr_pkg::S_LED: begin
                if (w_new_leds == r_leds || w_can_emit) begin
                    n_leds = w_new_leds;
                    n_prev = r_keys;
                end
            end
            default: ;
        endcase

        // one result held back until it is known whether it closes the request
        if (w_fin_push) begin
            n_ov    = 1'b1;
            n_okind = r_hkind;
            n_oval  = r_hval;
            n_olast = 1'b1;
            n_hv    = 1'b0;
        end else if (w_emit && w_can_emit) begin
            if (r_hv) begin
                n_ov    = 1'b1;
                n_okind = r_hkind;
                n_oval  = r_hval;
                n_olast = 1'b0;
            end else if (r_ov && i_m_axis_tready) begin
                n_ov = 1'b0;
            end
            n_hv    = 1'b1;
            n_hkind = w_emit_kind;
            n_hval  = w_emit_val;
        end else if (r_ov && i_m_axis_tready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hkr_pkg::S_CLEAR;
            r_clr   <= '0;
            r_ract  <= 1'b0;
            r_cd    <= '0;
            r_rcnt  <= '0;
            r_leds  <= '0;
            r_hv    <= 1'b0;
            r_ov    <= 1'b0;
            for (int k = 0; k < hkr_pkg::KEYS; k++) begin
                r_prev[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ract  <= n_ract;
            r_cd    <= n_cd;
            r_rcnt  <= n_rcnt;
            r_leds  <= n_leds;
            r_hv    <= n_hv;
            r_ov    <= n_ov;
            r_prev  <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_keys    <= n_keys;
        r_rb      <= n_rb;
        r_i       <= n_i;
        r_pos     <= n_pos;
        r_caps    <= n_caps;
        r_num     <= n_num;
        r_shift   <= n_shift;
        r_ctrl    <= n_ctrl;
        r_alt     <= n_alt;
        r_altgr   <= n_altgr;
        r_tick    <= n_tick;
        r_look_ok <= n_look_ok;
        r_hkind   <= n_hkind;
        r_hval    <= n_hval;
        r_okind   <= n_okind;
        r_oval    <= n_oval;
        r_olast   <= n_olast;
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_oval;
    assign o_m_axis_tuser  = r_okind;
    assign o_m_axis_tlast  = r_olast;

endmodule

[rtl/core/hkr_checker.sv]
// port-level checks for the keyboard report translator, bound to the top level
module hkr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [1:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata)
        && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

    // keymap clear keeps input closed after reset
    a_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_s_axis_tready)
        else $error("input ready during keymap clear");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser != 2'd3)
        else $error("unused result kind");

    // led update closes a report
    a_led_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == hkr_pkg::KIND_LEDS |-> o_m_axis_tlast)
        else $error("led update not last");

endmodule

bind hid_keyboard_report_to_ascii hkr_checker u_hkr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
